@@ design/cvdac_pkg.sv @@
// Shared types and constants for the calibrated CV DAC framer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cvdac_pkg;

  // Fixed field widths.
  localparam int VOLT_W = 17;  // requested voltage, signed, 1/4096 V
  localparam int VC_W   = 16;  // clamped voltage, enough for fifteen volts
  localparam int FRAC_W = 12;  // fraction bits of one volt
  localparam int IDX_W  = 4;   // table index within one channel
  localparam int OFFS_W = 16;  // offset in DAC LSBs, signed
  localparam int CODE_W = 12;  // framed DAC code
  localparam int SUM_W  = 21;  // code plus offset before saturation
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    OP_CAL_SET   = 2'd0,
    OP_RAW_SET   = 2'd1,
    OP_CAL_LOAD  = 2'd2,
    OP_CAL_CLEAR = 2'd3
  } op_e;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic gain;
    logic active;
  } cfg_t;

  // Width of clamped voltage times DAC_MAX.
  function automatic int prod_width(input int max_volts, input int dac_max);
    longint unsigned pmax;
    pmax = longint'(max_volts) * (longint'(1) << FRAC_W) * longint'(dac_max);
    return $clog2(pmax + 1);
  endfunction

endpackage

`default_nettype wire

@@ design/calibrated_cv_dac_frame.sv @@
// Calibrated CV DAC framer. Takes one word per clock when not stalled and returns
// one result word per input word, through the stage-one and output registers. The
// first stage clamps the voltage, forms the table addresses, starts the scaling
// multiply and reads two neighboring offsets from the table memory; the second
// stage scales, interpolates, saturates and packs the frame into the output
// register. Throughput is one word per cycle when not stalled, set by the two read
// ports of the table memory that serve both interpolation points at once. A table
// clear takes effect at once through per-entry valid bits, so no clearing pass
// follows reset. Depends on cvdac_pkg, cvdac_cfg, cvdac_cal_mem and cvdac_conv.
`default_nettype none

module calibrated_cv_dac_frame #(
  parameter int MAX_VOLTS  = 10,
  parameter int DAC_MAX    = 4095,
  parameter int CAL_POINTS = 10
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cvdac_pkg::APB_AW-1:0]        paddr,
  input  wire logic [cvdac_pkg::APB_DW-1:0]        pwdata,
  output logic      [cvdac_pkg::APB_DW-1:0]        prdata,
  output logic                                     pready,
  // Input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          op_i,
  input  wire logic                                channel_i,
  input  wire logic signed [cvdac_pkg::VOLT_W-1:0] volts_fixed_i,
  input  wire logic [cvdac_pkg::IDX_W-1:0]         cal_index_i,
  input  wire logic signed [cvdac_pkg::OFFS_W-1:0] cal_offset_i,
  // Output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     frame_valid_o,
  output logic [15:0]                              dac_frame_o,
  output logic [cvdac_pkg::CODE_W-1:0]             dac_code_o,
  output logic                                     status_o
);
  import cvdac_pkg::*;

  localparam int FULL_SCALE = MAX_VOLTS << FRAC_W;
  localparam int DEPTH      = 2 * CAL_POINTS;
  localparam int AW         = $clog2(DEPTH);
  localparam int PW         = prod_width(MAX_VOLTS, DAC_MAX);

  cfg_t cfg;

  // Handshake
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_adv, accept;

  // Input stage
  op_e                     op_in;
  logic                    v_neg, v_over;
  logic [VC_W-1:0]         vc;
  logic [IDX_W-1:0]        whole;
  logic [IDX_W-1:0]        hi_idx, lo_idx, whole_m1;
  logic [AW-1:0]           base, rd_addr_lo, rd_addr_hi, wr_addr;
  logic                    wr_en, clr;
  logic [PW-1:0]           prod;

  // Stage-one registers
  op_e                     s1_op_q;
  logic                    s1_ch_q;
  logic                    s1_bad_q;
  logic                    s1_lo_zero_q;
  logic [FRAC_W-1:0]       s1_frac_q;
  logic [PW-1:0]           s1_prod_q;

  logic signed [OFFS_W-1:0] rd_lo, rd_hi, lo_val;
  logic                     send;
  logic [CODE_W-1:0]        code;
  logic                     status;
  logic [CODE_W-1:0]        last_code_q [2];
  logic [CODE_W-1:0]        held_code;

  logic                     frame_valid_q;
  logic [15:0]              dac_frame_q;
  logic [CODE_W-1:0]        dac_code_q;
  logic                     status_q;

  cvdac_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The output register frees when empty or when its word is taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Clamp to 0..full scale; a raw set outside that range is rejected.
  assign op_in  = op_e'(op_i);
  assign v_neg  = volts_fixed_i[VOLT_W-1];
  assign v_over = !v_neg && (volts_fixed_i > VOLT_W'(FULL_SCALE));

  always_comb begin
    if (v_neg) begin
      vc = '0;
    end else if (v_over) begin
      vc = VC_W'(FULL_SCALE);
    end else begin
      vc = volts_fixed_i[VC_W-1:0];
    end
  end

  // Whole volts select the segment; the upper end point saturates to the last entry.
  assign whole    = vc[VC_W-1:FRAC_W];
  assign whole_m1 = whole - 1'b1;
  assign hi_idx   = ({1'b0, whole} > (IDX_W+1)'(CAL_POINTS - 1)) ?
                    IDX_W'(CAL_POINTS - 1) : whole;
  assign lo_idx   = ({1'b0, whole_m1} > (IDX_W+1)'(CAL_POINTS - 1)) ?
                    IDX_W'(CAL_POINTS - 1) : whole_m1;

  assign base       = channel_i ? AW'(CAL_POINTS) : '0;
  assign rd_addr_hi = base + AW'(hi_idx);
  assign rd_addr_lo = base + AW'(lo_idx);
  assign wr_addr    = base + AW'(cal_index_i);

  assign wr_en = accept && (op_in == OP_CAL_LOAD) &&
                 ({1'b0, cal_index_i} < (IDX_W+1)'(CAL_POINTS));
  assign clr   = accept && (op_in == OP_CAL_CLEAR);

  assign prod = PW'(vc) * PW'(DAC_MAX);

  cvdac_cal_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cal_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (cal_offset_i),
    .clr_i       (clr),
    .rd_en_i     (accept),
    .rd_addr_a_i (rd_addr_lo),
    .rd_addr_b_i (rd_addr_hi),
    .rd_data_a_o (rd_lo),
    .rd_data_b_o (rd_hi)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q      <= op_in;
      s1_ch_q      <= channel_i;
      s1_bad_q     <= v_neg || v_over;
      s1_lo_zero_q <= (whole == '0);
      s1_frac_q    <= vc[FRAC_W-1:0];
      s1_prod_q    <= prod;
    end
  end

  // Below one volt the segment starts from a zero offset.
  assign lo_val = s1_lo_zero_q ? '0 : rd_lo;

  cvdac_conv #(
    .MAX_VOLTS (MAX_VOLTS),
    .DAC_MAX   (DAC_MAX),
    .PW        (PW)
  ) u_conv (
    .op_i      (s1_op_q),
    .raw_bad_i (s1_bad_q),
    .prod_i    (s1_prod_q),
    .lo_i      (lo_val),
    .hi_i      (rd_hi),
    .frac_i    (s1_frac_q),
    .send_o    (send),
    .code_o    (code),
    .status_o  (status)
  );

  assign held_code = send ? code : last_code_q[s1_ch_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_code_q[0] <= '0;
      last_code_q[1] <= '0;
    end else if (s1_adv && send) begin
      last_code_q[s1_ch_q] <= code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      frame_valid_q <= send;
      dac_frame_q   <= send ? {s1_ch_q, 1'b0, cfg.gain, cfg.active, code} : '0;
      dac_code_q    <= held_code;
      status_q      <= status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_valid_o = frame_valid_q;
  assign dac_frame_o   = dac_frame_q;
  assign dac_code_o    = dac_code_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

@@ design/cvdac_cfg.sv @@
// APB register file holding the gain and active frame bits.
// Depends on cvdac_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module cvdac_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cvdac_pkg::APB_AW-1:0]   paddr,
  input  wire logic [cvdac_pkg::APB_DW-1:0]   pwdata,
  output logic      [cvdac_pkg::APB_DW-1:0]   prdata,
  output logic                                pready,
  output cvdac_pkg::cfg_t                     cfg_o
);
  import cvdac_pkg::*;

  logic gain_q, gain_d;
  logic active_q, active_d;
  logic wr_en;
  logic rd_bit;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    gain_d   = gain_q;
    active_d = active_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_GAIN:   gain_d   = pwdata[0];
        REG_ACTIVE: active_d = pwdata[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 1'b1;
      active_q <= 1'b1;
    end else begin
      gain_q   <= gain_d;
      active_q <= active_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GAIN:   rd_bit = gain_q;
      REG_ACTIVE: rd_bit = active_q;
      default:    rd_bit = 1'b0;
    endcase
  end

  assign prdata = {{(APB_DW-1){1'b0}}, rd_bit};
  assign cfg_o  = '{gain: gain_q, active: active_q};

endmodule

`default_nettype wire

@@ design/cvdac_cal_mem.sv @@
// Offset table for both channels: one write port, two registered read ports.
// Per-entry valid bits give the all-zero reset and the whole-table clear.
`default_nettype none

module cvdac_cal_mem #(
  parameter int DEPTH = 20,
  parameter int AW    = 5
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wr_en_i,
  input  wire logic [AW-1:0]                       wr_addr_i,
  input  wire logic signed [cvdac_pkg::OFFS_W-1:0] wr_data_i,
  input  wire logic                                clr_i,
  input  wire logic                                rd_en_i,
  input  wire logic [AW-1:0]                       rd_addr_a_i,
  input  wire logic [AW-1:0]                       rd_addr_b_i,
  output logic signed [cvdac_pkg::OFFS_W-1:0]      rd_data_a_o,
  output logic signed [cvdac_pkg::OFFS_W-1:0]      rd_data_b_o
);
  import cvdac_pkg::*;

  logic signed [OFFS_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         vld_q;
  logic signed [OFFS_W-1:0] rd_a_q, rd_b_q;
  logic                     rd_a_vld_q, rd_b_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q     <= mem[rd_addr_a_i];
      rd_b_q     <= mem[rd_addr_b_i];
      rd_a_vld_q <= vld_q[rd_addr_a_i];
      rd_b_vld_q <= vld_q[rd_addr_b_i];
    end
  end

  // An entry never written since reset or the last clear reads as zero.
  assign rd_data_a_o = rd_a_vld_q ? rd_a_q : '0;
  assign rd_data_b_o = rd_b_vld_q ? rd_b_q : '0;

endmodule

`default_nettype wire

@@ design/cvdac_conv.sv @@
// Second-stage arithmetic: scale to a DAC code, interpolate the offset,
// round, add and saturate, then pick the result by operation. Uses cvdac_pkg.
`default_nettype none

module cvdac_conv #(
  parameter int MAX_VOLTS = 10,
  parameter int DAC_MAX   = 4095,
  parameter int PW        = 32
) (
  input  wire cvdac_pkg::op_e                      op_i,
  input  wire logic                                raw_bad_i,
  input  wire logic [PW-1:0]                       prod_i,
  input  wire logic signed [cvdac_pkg::OFFS_W-1:0] lo_i,
  input  wire logic signed [cvdac_pkg::OFFS_W-1:0] hi_i,
  input  wire logic [cvdac_pkg::FRAC_W-1:0]        frac_i,
  output logic                                     send_o,
  output logic [cvdac_pkg::CODE_W-1:0]             code_o,
  output logic                                     status_o
);
  import cvdac_pkg::*;

  localparam int FULL_SCALE = MAX_VOLTS << FRAC_W;
  localparam int NW         = PW + 2;
  localparam int DIV_SH     = FRAC_W + 1;
  localparam int QW         = NW - DIV_SH;
  localparam int L          = $clog2(MAX_VOLTS);
  localparam int SH         = QW + L;
  localparam longint unsigned RECIP =
      ((longint'(1) << SH) + longint'(MAX_VOLTS) - 1) / longint'(MAX_VOLTS);
  localparam int RW         = $clog2(RECIP + 1);
  localparam int MW         = QW + RW;
  localparam int CW         = $clog2(DAC_MAX + 1);

  logic [NW-1:0]              num_code;
  logic [QW-1:0]              q1;
  logic [MW-1:0]              mprod;
  logic [QW-1:0]              q;
  logic [CW-1:0]              code_raw;

  logic signed [OFFS_W:0]     diff;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [29:0]         iprod;
  logic [30:0]                lo_ext;
  logic signed [30:0]         inum;
  logic [30:0]                mag;
  logic [30:0]                rsum;
  logic [18:0]                rmag;
  logic signed [19:0]         offs;
  logic signed [SUM_W-1:0]    sum;
  logic [CW-1:0]              code_cal;
  logic [CW-1:0]              code_sel;

  // Code = round(v * DAC_MAX / full scale). The divide by 2*full scale is a
  // shift by 13 followed by an exact reciprocal multiply for MAX_VOLTS.
  assign num_code = (NW'(prod_i) << 1) + NW'(FULL_SCALE);
  assign q1       = num_code[NW-1:DIV_SH];
  assign mprod    = MW'(q1) * MW'(RECIP);
  assign q        = QW'(mprod >> SH);
  assign code_raw = (q > QW'(DAC_MAX)) ? CW'(DAC_MAX) : CW'(q);

  // Offset = lo + (hi - lo) * frac / 4096, rounded half away from zero.
  assign diff   = (OFFS_W+1)'(hi_i) - (OFFS_W+1)'(lo_i);
  assign frac_s = signed'({1'b0, frac_i});
  assign iprod  = diff * frac_s;
  assign lo_ext = {{3{lo_i[OFFS_W-1]}}, lo_i, {FRAC_W{1'b0}}};
  assign inum   = signed'(lo_ext) + signed'({iprod[29], iprod});
  assign mag    = inum[30] ? 31'(-inum) : 31'(inum);
  assign rsum   = mag + 31'd2048;
  assign rmag   = rsum[30:FRAC_W];
  assign offs   = inum[30] ? -signed'({1'b0, rmag}) : signed'({1'b0, rmag});

  assign sum = signed'(SUM_W'(code_raw)) + SUM_W'(offs);

  always_comb begin
    if (sum[SUM_W-1]) begin
      code_cal = '0;
    end else if (sum > SUM_W'(DAC_MAX)) begin
      code_cal = CW'(DAC_MAX);
    end else begin
      code_cal = CW'(sum);
    end
  end

  always_comb begin
    send_o   = 1'b0;
    status_o = STATUS_OK;
    code_sel = code_raw;
    case (op_i)
      OP_CAL_SET: begin
        send_o   = 1'b1;
        code_sel = code_cal;
      end
      OP_RAW_SET: begin
        if (raw_bad_i) begin
          status_o = STATUS_RANGE;
        end else begin
          send_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign code_o = CODE_W'(code_sel);

endmodule

`default_nettype wire
